// ===== hdl/sut_pkg.sv =====
// ============================================================================
// sut_pkg : shared definitions for the sorted unique set table
// Field widths, command and status codes, and the control bundle that the
// top level broadcasts to every cell of the chain.
// ============================================================================
package sut_pkg;

   localparam int CAPACITY_DEFAULT = 64;

   localparam int KEY_W    = 32;
   localparam int CMD_W    = 2;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 7;

   localparam logic [CMD_W-1:0] CMD_INSERT   = 2'd0;
   localparam logic [CMD_W-1:0] CMD_ERASE    = 2'd1;
   localparam logic [CMD_W-1:0] CMD_CONTAINS = 2'd2;

   localparam logic [STATUS_W-1:0] ST_DONE = 2'd0;
   localparam logic [STATUS_W-1:0] ST_MISS = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

   // per-cycle command to all cells
   typedef struct packed {
      logic capture;     // compare own entry with the broadcast key
      logic shift_up;    // open a gap at the insert position
      logic shift_down;  // close the gap at the erased entry
   } sut_cell_ctl_type;

endpackage

// ===== hdl/sut_cell.sv =====
// ============================================================================
// sut_cell : one slot of the sorted key chain
// Holds one key, compares it with the broadcast key and moves keys to or
// from its neighbors when the table opens or closes a gap.
// ============================================================================
module sut_cell
   import sut_pkg::*;
#(
   parameter int INDEX = 0,
   parameter int CNT_W = 7
) (
   input  logic                    clock,
   input  sut_cell_ctl_type        ctl,
   input  logic [CNT_W-1:0]        count,
   input  logic signed [KEY_W-1:0] key,
   input  logic signed [KEY_W-1:0] prev_entry,
   input  logic                    prev_lt,
   input  logic signed [KEY_W-1:0] next_entry,
   output logic signed [KEY_W-1:0] entry,
   output logic                    lt,
   output logic                    eq
);

   logic signed [KEY_W-1:0] entry_ff, entry_in;
   logic                    lt_ff, lt_in;
   logic                    eq_ff, eq_in;
   logic                    valid;

   assign valid = CNT_W'(INDEX) < count;

   always_comb begin
      lt_in    = lt_ff;
      eq_in    = eq_ff;
      entry_in = entry_ff;
      if (ctl.capture) begin
         lt_in = valid && (entry_ff < key);
         eq_in = valid && (entry_ff == key);
      end
      // keys below the search key never move
      if (ctl.shift_up && !lt_ff) begin
         entry_in = prev_lt ? key : prev_entry;
      end
      if (ctl.shift_down && !lt_ff) begin
         entry_in = next_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      lt_ff    <= lt_in;
      eq_ff    <= eq_in;
   end

   assign entry = entry_ff;
   assign lt    = lt_ff;
   assign eq    = eq_ff;

endmodule

// ===== hdl/sorted_unique_set_table_unit.sv =====
// ============================================================================
// sorted_unique_set_table_unit : sorted set of distinct signed keys
// Insert, erase and membership test over a chain of key cells kept in
// ascending signed order, one status and element count per command.
// ============================================================================
//
// A command passes through the states S_IDLE, which captures it, S_CMP,
// in which every cell compares its key with the command key, S_RES, which
// reduces the per-cell match flags to a single hit, and S_APPLY, in which
// the chain shifts by one slot (insert or erase) and the result is formed.
// The result strobe rsp_valid is high for exactly one cycle, in the
// cycle where busy drops again, so a new command may be issued while the
// previous result is on the ports. The receiver cannot hold results off;
// sample rsp_status and rsp_element_count whenever rsp_valid is high. An
// insert of a key already held reports miss even when the table is
// full; an insert into a full table reports full and changes nothing. An
// unused command code changes nothing and reports absent. The element count
// is seven bits wide and wraps for capacities above 127. No clearing pass
// runs after reset: the table is empty once reset is released.
//
module sorted_unique_set_table_unit
   import sut_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  logic [CMD_W-1:0]        req_command,
   input  logic signed [KEY_W-1:0] req_key,
   output logic                    rsp_valid,
   output logic [STATUS_W-1:0]     rsp_status,
   output logic [COUNT_W-1:0]      rsp_element_count
);

   localparam int CNT_W = $clog2(CAPACITY + 1);

   typedef enum logic [3:0] {
      S_IDLE  = 4'b0001,
      S_CMP   = 4'b0010,
      S_RES   = 4'b0100,
      S_APPLY = 4'b1000
   } state_type;

   state_type               state_ff, state_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic [CMD_W-1:0]        cmd_ff, cmd_in;
   logic signed [KEY_W-1:0] key_ff, key_in;
   logic                    hit_ff, hit_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]     status_ff, status_in;
   logic [COUNT_W-1:0]      rsp_count_ff, rsp_count_in;

   sut_cell_ctl_type        ctl;
   logic                    full;
   logic                    accept;
   logic [CNT_W+COUNT_W-1:0] count_wide;

   logic signed [KEY_W-1:0] entry_vec [CAPACITY];
   logic [CAPACITY-1:0]     lt_vec;
   logic [CAPACITY-1:0]     eq_vec;

   assign accept = start && !busy;
   assign full   = count_ff == CNT_W'(CAPACITY);

   // ---------------------------------------------------------------------
   // Cell chain: slot 0 holds the smallest key
   // ---------------------------------------------------------------------
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic signed [KEY_W-1:0] prev_entry;
      logic                    prev_lt;
      logic signed [KEY_W-1:0] next_entry;

      if (i == 0) begin : g_first
         // slot 0 has nothing below it, so it takes the key when it opens
         assign prev_entry = key_ff;
         assign prev_lt    = 1'b1;
      end else begin : g_mid
         assign prev_entry = entry_vec[i-1];
         assign prev_lt    = lt_vec[i-1];
      end

      if (i == CAPACITY - 1) begin : g_last
         // the top slot falls out of range on erase; keep its own key
         assign next_entry = entry_vec[i];
      end else begin : g_up
         assign next_entry = entry_vec[i+1];
      end

      sut_cell #(
         .INDEX (i),
         .CNT_W (CNT_W)
      ) u_cell (
         .clock      (clock),
         .ctl        (ctl),
         .count      (count_ff),
         .key        (key_ff),
         .prev_entry (prev_entry),
         .prev_lt    (prev_lt),
         .next_entry (next_entry),
         .entry      (entry_vec[i]),
         .lt         (lt_vec[i]),
         .eq         (eq_vec[i])
      );
   end

   // ---------------------------------------------------------------------
   // Sequencer
   // ---------------------------------------------------------------------
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      cmd_in       = cmd_ff;
      key_in       = key_ff;
      hit_in       = hit_ff;
      rsp_valid_in = 1'b0;
      status_in    = status_ff;
      ctl          = '0;

      unique case (state_ff)
         S_IDLE: begin
            // hold the command and key for the whole item
            if (start) begin
               cmd_in   = req_command;
               key_in   = req_key;
               state_in = S_CMP;
            end
         end
         S_CMP: begin
            ctl.capture = 1'b1;
            state_in    = S_RES;
         end
         S_RES: begin
            // keys are distinct, so at most one cell matches
            hit_in   = |eq_vec;
            state_in = S_APPLY;
         end
         S_APPLY: begin
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
            unique case (cmd_ff)
               CMD_INSERT: begin
                  if (hit_ff) begin
                     status_in = ST_MISS;
                  end else if (full) begin
                     status_in = ST_FULL;
                  end else begin
                     ctl.shift_up = 1'b1;
                     count_in     = count_ff + 1'b1;
                     status_in    = ST_DONE;
                  end
               end
               CMD_ERASE: begin
                  if (hit_ff) begin
                     ctl.shift_down = 1'b1;
                     count_in       = count_ff - 1'b1;
                     status_in      = ST_DONE;
                  end else begin
                     status_in = ST_MISS;
                  end
               end
               CMD_CONTAINS: begin
                  status_in = hit_ff ? ST_DONE : ST_MISS;
               end
               default: begin
                  status_in = ST_MISS;
               end
            endcase
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // report the count modulo 128
   assign count_wide   = {{COUNT_W{1'b0}}, count_in};
   assign rsp_count_in = count_wide[COUNT_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      key_ff       <= key_in;
      hit_ff       <= hit_in;
      status_ff    <= status_in;
      rsp_count_ff <= rsp_count_in;
   end

   assign busy              = !state_ff[0];
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = status_ff;
   assign rsp_element_count = rsp_count_ff;

   // ---------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------
   a_rsp_after_apply: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(state_ff == S_APPLY))
      else $error("result strobe without a preceding apply cycle");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("element count above capacity");

   a_count_moves_in_apply: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && (count_ff != $past(count_ff))) |->
         ($past(state_ff == S_APPLY) && rsp_valid))
      else $error("element count changed outside an apply cycle");

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == S_CMP))
      else $error("accepted item did not start the compare cycle");

   a_done_insert_grows: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == ST_DONE) && (cmd_ff == CMD_INSERT)) |->
         (count_ff == $past(count_ff) + 1'b1))
      else $error("successful insert did not grow the table");

endmodule

// ===== tb/sorted_unique_set_table_unit_tb.sv =====
`timescale 1ns / 100ps
// ============================================================================
// sorted_unique_set_table_unit_tb : self-checking bench for the sorted set
// Drives insert, erase, membership and unused commands through the start/busy
// handshake and checks every status and element count against a behavioral
// copy of the set or a typed-in result. A short directed table comes first,
// followed by a phase that fills the table to capacity and a long random run
// with varied command mixes and sender gaps.
// ============================================================================
module sorted_unique_set_table_unit_tb;
   import sut_pkg::*;

   localparam int SET_CAPACITY   = CAPACITY_DEFAULT;
   localparam int RANDOM_BLOCKS  = 15;      // blocks of 100 random commands
   localparam int BLOCK_ITEMS    = 100;
   localparam int POOL_SIZE      = 96;      // more keys than slots, so the table can fill
   localparam int WATCHDOG_LIMIT = 2000;    // cycles with no handshake at all
   localparam int SETTLE_CYCLES  = 20;      // quiet time after the last result

   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

   typedef logic signed [KEY_W-1:0] key_type;

   localparam key_type KEY_MIN = 32'sh8000_0000;
   localparam key_type KEY_MAX = 32'sh7FFF_FFFF;
   localparam key_type KEY_NEG1 = 32'shFFFF_FFFF;

   // one row of the directed table; known_result marks rows whose outcome
   // is typed in rather than taken from the set model
   typedef struct packed {
      logic [CMD_W-1:0]    cmd;
      logic [KEY_W-1:0]    key;
      logic                known_result;
      logic [STATUS_W-1:0] status;
      logic [COUNT_W-1:0]  count;
   } directed_row_type;

   typedef struct {
      int                  seq;
      logic [STATUS_W-1:0] status;
      logic [COUNT_W-1:0]  count;
   } outcome_type;

   localparam int DIRECTED_ROWS = 21;

   // directed commands: empty-table lookups, extreme keys, duplicates,
   // unused command code with the key held and not held, erase of a
   // missing key, middle erase, alternating bit patterns
   directed_row_type directed_table [DIRECTED_ROWS] = '{
      {CMD_CONTAINS, 32'sd0,       1'b1, ST_MISS, 7'd0},
      {CMD_ERASE,    32'sd5,       1'b1, ST_MISS, 7'd0},
      {CMD_UNUSED,   32'sd0,       1'b1, ST_MISS, 7'd0},
      {CMD_INSERT,   KEY_MIN,      1'b1, ST_DONE, 7'd1},
      {CMD_INSERT,   KEY_MAX,      1'b1, ST_DONE, 7'd2},
      {CMD_INSERT,   32'sd0,       1'b1, ST_DONE, 7'd3},
      {CMD_INSERT,   32'sd0,       1'b1, ST_MISS, 7'd3},
      {CMD_CONTAINS, KEY_MIN,      1'b1, ST_DONE, 7'd3},
      {CMD_CONTAINS, KEY_MAX,      1'b1, ST_DONE, 7'd3},
      {CMD_CONTAINS, KEY_NEG1,     1'b1, ST_MISS, 7'd3},
      {CMD_UNUSED,   KEY_MAX,      1'b1, ST_MISS, 7'd3},
      {CMD_ERASE,    KEY_MAX,      1'b1, ST_DONE, 7'd2},
      {CMD_ERASE,    KEY_MAX,      1'b1, ST_MISS, 7'd2},
      {CMD_INSERT,   KEY_NEG1,     1'b0, ST_DONE, 7'd0},
      {CMD_INSERT,   32'sd1,       1'b0, ST_DONE, 7'd0},
      {CMD_INSERT,   32'sh5555_5555, 1'b0, ST_DONE, 7'd0},
      {CMD_INSERT,   32'shAAAA_AAAA, 1'b0, ST_DONE, 7'd0},
      {CMD_CONTAINS, 32'shAAAA_AAAA, 1'b0, ST_DONE, 7'd0},
      {CMD_ERASE,    KEY_MIN,      1'b0, ST_DONE, 7'd0},
      {CMD_ERASE,    32'sd0,       1'b0, ST_DONE, 7'd0},
      {CMD_CONTAINS, 32'sd1,       1'b0, ST_DONE, 7'd0}
   };

   logic                clock;
   logic                reset;
   logic                start;
   logic                busy;
   logic [CMD_W-1:0]    req_command;
   key_type             req_key;
   logic                rsp_valid;
   logic [STATUS_W-1:0] rsp_status;
   logic [COUNT_W-1:0]  rsp_element_count;

   // behavioral copy of the set: ascending keys in slots 0 .. set_size-1
   key_type     set_keys [SET_CAPACITY];
   int          set_size;
   key_type     key_pool [POOL_SIZE];
   outcome_type pending_outcomes [$];
   int          error_count;
   int          accepted_count;
   int          no_idle_run;
   int          idle_cycles;

   sorted_unique_set_table_unit #(
      .CAPACITY(SET_CAPACITY)
   ) DUT (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_command       (req_command),
      .req_key           (req_key),
      .rsp_valid         (rsp_valid),
      .rsp_status        (rsp_status),
      .rsp_element_count (rsp_element_count)
   );

   initial clock = 1'b0;
   always #4 clock = ~clock;

   task automatic report_mismatch(input string msg);
      error_count++;
      $display("MISMATCH @%0t: %s", $time, msg);
   endtask

   // Apply one command to the set copy and return the status and the
   // element count that the block must report for it.
   function automatic void apply_set_command(input logic [CMD_W-1:0] cmd, input key_type key,
                                             output logic [STATUS_W-1:0] status,
                                             output logic [COUNT_W-1:0] count);
      int pos;
      int i;
      bit hit;
      pos = 0;
      while (pos < set_size && set_keys[pos] < key)
         pos++;
      hit = (pos < set_size) && (set_keys[pos] == key);
      status = ST_MISS;
      case (cmd)
         CMD_INSERT: begin
            if (hit) begin
               status = ST_MISS;
            end else if (set_size >= SET_CAPACITY) begin
               status = ST_FULL;
            end else begin
               for (i = set_size; i > pos; i--)
                  set_keys[i] = set_keys[i-1];
               set_keys[pos] = key;
               set_size++;
               status = ST_DONE;
            end
         end
         CMD_ERASE: begin
            if (hit) begin
               for (i = pos; i < set_size - 1; i++)
                  set_keys[i] = set_keys[i+1];
               set_size--;
               status = ST_DONE;
            end
         end
         CMD_CONTAINS: begin
            if (hit)
               status = ST_DONE;
         end
         default: status = ST_MISS;
      endcase
      count = set_size[COUNT_W-1:0];
   endfunction

   // Mostly pool keys, so inserts collide and erases hit; some keys already
   // held, and some fully random values to toggle every key bit.
   function automatic key_type pick_key();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70)
         return key_pool[$urandom_range(0, POOL_SIZE - 1)];
      else if (r < 85 && set_size > 0)
         return set_keys[$urandom_range(0, set_size - 1)];
      else
         return $urandom;
   endfunction

   // Present one command, hold it until accepted, then record the outcome.
   // The sender gap is drawn per item, with occasional back-to-back runs.
   task automatic send_item(input logic [CMD_W-1:0] cmd, input key_type key,
                            input logic known_result, input logic [STATUS_W-1:0] known_status,
                            input logic [COUNT_W-1:0] known_count);
      int gap;
      outcome_type want;
      if (no_idle_run > 0) begin
         no_idle_run--;
         gap = 0;
      end else if ($urandom_range(0, 9) == 0) begin
         no_idle_run = $urandom_range(5, 30);
         gap = 0;
      end else begin
         gap = $urandom_range(0, 19);
      end
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start       <= 1'b1;
      req_command <= cmd;
      req_key     <= key;
      @(posedge clock);
      while (busy !== 1'b0)
         @(posedge clock);
      // accepted at this edge: update the set copy now
      accepted_count++;
      want.seq = accepted_count;
      apply_set_command(cmd, key, want.status, want.count);
      if (known_result) begin
         want.status = known_status;
         want.count  = known_count;
      end
      pending_outcomes.push_back(want);
   endtask

   // Drop start and hold off until every outstanding result has come back.
   task automatic wait_for_results();
      start <= 1'b0;
      @(posedge clock);
      while (pending_outcomes.size() != 0)
         @(posedge clock);
   endtask

   // Result checker: a result is accepted at the edge that ends its strobe
   // cycle, compare it with the oldest outstanding outcome.
   always @(posedge clock) begin : check_results
      outcome_type want;
      if (!reset && rsp_valid === 1'b1) begin
         if (pending_outcomes.size() == 0) begin
            report_mismatch($sformatf("unexpected result: status %0d count %0d",
                                      rsp_status, rsp_element_count));
         end else begin
            want = pending_outcomes.pop_front();
            if (rsp_status !== want.status)
               report_mismatch($sformatf("item %0d status: got %0d want %0d",
                                         want.seq, rsp_status, want.status));
            if (rsp_element_count !== want.count)
               report_mismatch($sformatf("item %0d element_count: got %0d want %0d",
                                         want.seq, rsp_element_count, want.count));
         end
      end
   end

   // Watchdog: count cycles with neither a command nor a result handshake.
   always @(posedge clock) begin
      if (reset || (start === 1'b1 && busy === 1'b0) || rsp_valid === 1'b1) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog expired after %0d idle cycles", idle_cycles);
            $display("Simulation FAILED");
            $finish;
         end
      end
   end

   initial begin : stimulus
      int row;
      int blk;
      int n;
      int r;
      int insert_pct;
      int erase_pct;
      logic [CMD_W-1:0] cmd;

      // drive every input to a known value before the first edge
      reset          = 1'b1;
      start          = 1'b0;
      req_command    = CMD_INSERT;
      req_key        = '0;
      set_size       = 0;
      error_count    = 0;
      accepted_count = 0;
      no_idle_run    = 0;

      // seed the key pool with the extremes, a few neighbors and random keys
      key_pool[0] = KEY_MIN;
      key_pool[1] = KEY_MAX;
      key_pool[2] = 32'sd0;
      key_pool[3] = KEY_NEG1;
      key_pool[4] = 32'sd1;
      for (n = 5; n < POOL_SIZE; n++) begin
         if (n % 8 == 0)
            key_pool[n] = key_pool[n-1] + 1;
         else
            key_pool[n] = $urandom;
      end

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed table
      for (row = 0; row < DIRECTED_ROWS; row++)
         send_item(directed_table[row].cmd, directed_table[row].key,
                   directed_table[row].known_result, directed_table[row].status,
                   directed_table[row].count);

      // hold the sender until the block has drained completely
      wait_for_results();

      // fill the table to capacity, then hit it with refused inserts,
      // duplicates of held keys, lookups and a single erase/insert churn
      while (set_size < SET_CAPACITY)
         send_item(CMD_INSERT, $urandom, 1'b0, ST_DONE, '0);
      for (n = 0; n < 4; n++) begin
         send_item(CMD_INSERT, $urandom, 1'b0, ST_DONE, '0);
         send_item(CMD_INSERT, set_keys[$urandom_range(0, set_size - 1)], 1'b0, ST_DONE, '0);
         send_item(CMD_CONTAINS, set_keys[$urandom_range(0, set_size - 1)], 1'b0, ST_DONE, '0);
      end
      send_item(CMD_ERASE, set_keys[SET_CAPACITY - 1], 1'b0, ST_DONE, '0);
      send_item(CMD_INSERT, KEY_MAX, 1'b0, ST_DONE, '0);
      send_item(CMD_INSERT, KEY_MIN, 1'b0, ST_DONE, '0);
      send_item(CMD_UNUSED, set_keys[0], 1'b0, ST_DONE, '0);

      // random blocks, each with its own command mix: filling, draining
      // or balanced, so the table sweeps between empty and full
      for (blk = 0; blk < RANDOM_BLOCKS; blk++) begin
         case ($urandom_range(0, 2))
            0:       begin insert_pct = 65; erase_pct = 10; end
            1:       begin insert_pct = 15; erase_pct = 60; end
            default: begin insert_pct = 35; erase_pct = 30; end
         endcase
         for (n = 0; n < BLOCK_ITEMS; n++) begin
            r = $urandom_range(0, 99);
            if (r < insert_pct)
               cmd = CMD_INSERT;
            else if (r < insert_pct + erase_pct)
               cmd = CMD_ERASE;
            else if (r < 95)
               cmd = CMD_CONTAINS;
            else
               cmd = CMD_UNUSED;
            send_item(cmd, pick_key(), 1'b0, ST_DONE, '0);
         end
         if ($urandom_range(0, 3) == 0)
            wait_for_results();
      end

      // drain, then give stray results a chance to show up
      wait_for_results();
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (error_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
